// File: rtl/assert_macros.svh
// Assertion macros shared by the heat update block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define VFH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VFH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/vfh_pkg.sv
// Shared types and constants of the volumetric fire heat update block.
package vfh_pkg;

  localparam int DefMaxWidth  = 32;
  localparam int DefMaxHeight = 32;
  localparam int DefMaxDepth  = 16;

  localparam int MinWidth       = 5;
  localparam int MinHeight      = 5;
  localparam int MinDepth       = 3;
  localparam int FallbackWidth  = 24;
  localparam int FallbackHeight = 24;
  localparam int FallbackDepth  = 16;
  localparam int WidthReset     = 24;
  localparam int HeightReset    = 24;
  localparam int DepthReset     = 16;

  localparam logic [31:0] SeedReset = 32'd1;

  localparam int SeedBase     = 180;
  localparam int SeedSpan     = 75;
  localparam int Recip75      = 111848;  // floor(2^23 / 75)
  localparam int Recip75Shift = 23;
  localparam int Recip5       = 3277;    // ceil(2^14 / 5)
  localparam int Recip5Shift  = 14;
  localparam int AvgFloor     = 3;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_RANGE    = 2'd1,
    STATUS_DISABLED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CFG_ENABLED = 3'd0,
    CFG_WIDTH   = 3'd1,
    CFG_HEIGHT  = 3'd2,
    CFG_DEPTH   = 3'd3,
    CFG_SEED    = 3'd4
  } cfg_index_e;

  typedef struct packed {
    logic load;
    logic advance;
  } rng_ctl_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] heat;
    status_e    status;
  } result_t;

endpackage

// File: rtl/volumetric_fire_heat_update_top.sv
// Top level of the volumetric fire heat update block.
// Usage: items enter on in_valid_i/in_ready_o with kind_i and a cell coordinate;
// each item gives exactly one result on out_valid_o/out_ready_i (heat_o, status_o).
// Configuration is written through cfg_we_i/cfg_index_i/cfg_data_i; the user
// must write it only while idle, and the block itself does not enforce this.
// A read item issues its memory read on acceptance, takes the data in S_CELL
// and offers its result in S_RESP; a disabled tick, an out-of-range read or an
// unknown kind goes straight to S_RESP. A clear item sweeps all 2^(XW+YW+ZW)
// memory entries, one a cycle (16384 with the default sizes). An enabled tick
// seeds w*d bottom cells at one a cycle, then averages each upper layer with
// one memory read port: a center read per row, three reads per cell, and an
// S_DRAIN wait per layer until pending writes land before the next layer reads
// them. One item is processed at a time; the read port sets the tick rate.
// Reset: the block runs a clearing pass over all 2^(XW+YW+ZW) entries (16384
// by default) with in_ready_o low; configuration writes are taken meanwhile.
// If the receiver stalls, the result waits in the output register; the next item
// may be accepted and worked on, and its result waits until the register is free.
`include "assert_macros.svh"

module volumetric_fire_heat_update_top #(
  parameter int MaxWidth  = vfh_pkg::DefMaxWidth,
  parameter int MaxHeight = vfh_pkg::DefMaxHeight,
  parameter int MaxDepth  = vfh_pkg::DefMaxDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [4:0]  cell_x_i,
  input  logic [4:0]  cell_y_i,
  input  logic [3:0]  cell_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  heat_o,
  output logic [1:0]  status_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int XW = $clog2(MaxWidth);
  localparam int YW = $clog2(MaxHeight);
  localparam int ZW = $clog2(MaxDepth);
  localparam int XS = XW + 1;
  localparam int YS = YW + 1;
  localparam int ZS = ZW + 1;
  localparam int AW = XW + YW + ZW;

  logic        cfg_enabled_q;
  logic [5:0]  cfg_width_q, cfg_height_q;
  logic [4:0]  cfg_depth_q;
  logic [31:0] cfg_seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_enabled_q <= 1'b0;
      cfg_width_q   <= 6'(vfh_pkg::WidthReset);
      cfg_height_q  <= 6'(vfh_pkg::HeightReset);
      cfg_depth_q   <= 5'(vfh_pkg::DepthReset);
      cfg_seed_q    <= vfh_pkg::SeedReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        vfh_pkg::CFG_ENABLED: cfg_enabled_q <= cfg_data_i[0];
        vfh_pkg::CFG_WIDTH:   cfg_width_q   <= cfg_data_i[5:0];
        vfh_pkg::CFG_HEIGHT:  cfg_height_q  <= cfg_data_i[5:0];
        vfh_pkg::CFG_DEPTH:   cfg_depth_q   <= cfg_data_i[4:0];
        vfh_pkg::CFG_SEED:    cfg_seed_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Sizes in use: too small falls back to the default, too large saturates.
  logic [5:0]    w_raw, h_raw;
  logic [4:0]    d_raw;
  logic [XS-1:0] w_use;
  logic [YS-1:0] h_use;
  logic [ZS-1:0] d_use;

  assign w_raw = (cfg_width_q < 6'(vfh_pkg::MinWidth)) ?
                 6'(vfh_pkg::FallbackWidth) : cfg_width_q;
  assign h_raw = (cfg_height_q < 6'(vfh_pkg::MinHeight)) ?
                 6'(vfh_pkg::FallbackHeight) : cfg_height_q;
  assign d_raw = (cfg_depth_q < 5'(vfh_pkg::MinDepth)) ?
                 5'(vfh_pkg::FallbackDepth) : cfg_depth_q;
  assign w_use = (32'(w_raw) > 32'(MaxWidth))  ? XS'(MaxWidth)  : XS'(w_raw);
  assign h_use = (32'(h_raw) > 32'(MaxHeight)) ? YS'(MaxHeight) : YS'(h_raw);
  assign d_use = (32'(d_raw) > 32'(MaxDepth))  ? ZS'(MaxDepth)  : ZS'(d_raw);

  vfh_pkg::rng_ctl_t rng_ctl;
  logic [15:0]       draw;
  vfh_pkg::result_t  res;
  logic              res_ready;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;

  vfh_rng u_rng (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (rng_ctl),
    .seed_i (cfg_seed_q),
    .draw_o (draw)
  );

  vfh_heat_mem #(
    .AddrWidth (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  vfh_ctrl #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight),
    .MaxDepth  (MaxDepth)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .cell_x_i    (cell_x_i),
    .cell_y_i    (cell_y_i),
    .cell_z_i    (cell_z_i),
    .enabled_i   (cfg_enabled_q),
    .w_i         (w_use),
    .h_i         (h_use),
    .d_i         (d_use),
    .draw_i      (draw),
    .rng_ctl_o   (rng_ctl),
    .res_o       (res),
    .res_ready_i (res_ready),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Output register between the sequencer and the receiver.
  logic             out_valid_q, out_valid_d;
  logic [7:0]       heat_q;
  vfh_pkg::status_e status_q;

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      heat_q   <= res.heat;
      status_q <= res.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign heat_o      = heat_q;
  assign status_o    = status_q;

  `VFH_ASSERT_NEXT(a_res_wait, res.valid && out_valid_q && !out_ready_i, res.valid, "result dropped while output stalled")

endmodule

// File: rtl/vfh_heat_mem.sv
// Heat volume storage: one write port and one registered read port.
module vfh_heat_mem #(
  parameter int AddrWidth = 14
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [7:0]           wdata_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [7:0]           rdata_o
);

  logic [7:0] mem_q [0:(1 << AddrWidth)-1];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/vfh_rng.sv
// Xorshift32 random generator with seed load and one draw per advance.
module vfh_rng (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vfh_pkg::rng_ctl_t ctl_i,
  input  logic [31:0]       seed_i,
  output logic [15:0]       draw_o
);

  logic [31:0] state_q, state_d;
  logic [31:0] s1, s2, s3;

  always_comb begin
    s1 = state_q ^ (state_q << 13);
    s2 = s1 ^ (s1 >> 17);
    s3 = s2 ^ (s2 << 5);
  end

  // A draw is the low half of the state after it advances.
  assign draw_o = s3[15:0];

  always_comb begin
    state_d = state_q;
    if (ctl_i.load) begin
      state_d = seed_i;
    end else if (ctl_i.advance) begin
      state_d = s3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vfh_pkg::SeedReset;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/vfh_ctrl.sv
// Sequencer and datapath: clearing sweep, seeding, layer averaging and cell reads.
`include "assert_macros.svh"

module vfh_ctrl #(
  parameter int MaxWidth  = vfh_pkg::DefMaxWidth,
  parameter int MaxHeight = vfh_pkg::DefMaxHeight,
  parameter int MaxDepth  = vfh_pkg::DefMaxDepth,
  localparam int XW = $clog2(MaxWidth),
  localparam int YW = $clog2(MaxHeight),
  localparam int ZW = $clog2(MaxDepth),
  localparam int XS = XW + 1,
  localparam int YS = YW + 1,
  localparam int ZS = ZW + 1,
  localparam int AW = XW + YW + ZW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        kind_i,
  input  logic [4:0]        cell_x_i,
  input  logic [4:0]        cell_y_i,
  input  logic [3:0]        cell_z_i,
  input  logic              enabled_i,
  input  logic [XS-1:0]     w_i,
  input  logic [YS-1:0]     h_i,
  input  logic [ZS-1:0]     d_i,
  input  logic [15:0]       draw_i,
  output vfh_pkg::rng_ctl_t rng_ctl_o,
  output vfh_pkg::result_t  res_o,
  input  logic              res_ready_i,
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_waddr_o,
  output logic [7:0]        mem_wdata_o,
  output logic              mem_re_o,
  output logic [AW-1:0]     mem_raddr_o,
  input  logic [7:0]        mem_rdata_i
);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_SEED  = 10'b00_0000_0100,
    S_DRAIN = 10'b00_0000_1000,
    S_RC    = 10'b00_0001_0000,
    S_RR    = 10'b00_0010_0000,
    S_RU    = 10'b00_0100_0000,
    S_RD    = 10'b00_1000_0000,
    S_CELL  = 10'b01_0000_0000,
    S_RESP  = 10'b10_0000_0000
  } state_e;

  // What the read issued in the previous cycle fetched.
  typedef enum logic [2:0] {
    TAG_NONE   = 3'd0,
    TAG_CENTER = 3'd1,
    TAG_RIGHT  = 3'd2,
    TAG_ZMINUS = 3'd3,
    TAG_ZPLUS  = 3'd4
  } rd_tag_e;

  function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x,
                                              input logic [YW-1:0] y,
                                              input logic [ZW-1:0] z);
    return {z, y, x};
  endfunction

  state_e            state_q, state_d;
  logic [XW-1:0]     x_q, x_d;
  logic [YW-1:0]     y_q, y_d;
  logic [ZW-1:0]     z_q, z_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic              clr_item_q, clr_item_d;
  logic              fin_q, fin_d;
  logic [7:0]        res_heat_q, res_heat_d;
  vfh_pkg::status_e  res_status_q, res_status_d;
  rd_tag_e           rd_tag_q, rd_tag_d;
  logic              rd_ok_q, rd_ok_d;
  logic [AW-1:0]     rd_cell_q, rd_cell_d;

  logic [7:0]        left_q, left_d, mid_q, mid_d, right_q, right_d, zm_q, zm_d;
  logic              s1_v_q, s1_v_d, s2_v_q;
  logic [10:0]       sum_q, sum_d;
  logic [AW-1:0]     s1_addr_q, s1_addr_d, s2_addr_q;
  logic [7:0]        avg_q, avg_d;

  logic              sa_v_q, sa_v_d, sb_v_q;
  logic [15:0]       sa_val_q, sa_val_d, sb_val_q;
  logic [AW-1:0]     sa_addr_q, sa_addr_d, sb_addr_q;
  logic [9:0]        sb_quo_q, sb_quo_d;

  logic [XS-1:0]     x_next;
  logic [ZS-1:0]     z_next;
  logic              x_last, z_last;
  logic [YW-1:0]     below, bottom;
  logic              in_range, pipe_busy, avg_hot;
  logic [7:0]        rd_val;
  logic [16:0]       rem_full;
  logic [7:0]        rem;

  assign x_next = XS'(x_q) + XS'(1);
  assign z_next = ZS'(z_q) + ZS'(1);
  assign x_last = !(x_next < w_i);
  assign z_last = !(z_next < d_i);
  assign below  = y_q + YW'(1);
  assign bottom = YW'(h_i - YS'(1));

  assign in_range = (32'(cell_x_i) < 32'(w_i)) && (32'(cell_y_i) < 32'(h_i)) &&
                    (32'(cell_z_i) < 32'(d_i));

  assign pipe_busy = sa_v_q || sb_v_q || s1_v_q || s2_v_q || (rd_tag_q != TAG_NONE);
  assign avg_hot   = s2_v_q && (avg_q > 8'(vfh_pkg::AvgFloor));

  assign in_ready_o = (state_q == S_IDLE);

  // Sequencer: one read per cycle; averaging takes three reads per cell.
  always_comb begin
    state_d      = state_q;
    x_d          = x_q;
    y_d          = y_q;
    z_d          = z_q;
    clr_d        = clr_q;
    clr_item_d   = clr_item_q;
    fin_d        = fin_q;
    res_heat_d   = res_heat_q;
    res_status_d = res_status_q;
    rd_tag_d     = TAG_NONE;
    rd_ok_d      = 1'b0;
    rd_cell_d    = rd_cell_q;
    mem_re_o     = 1'b0;
    mem_raddr_o  = '0;
    sa_v_d       = 1'b0;
    sa_val_d     = sa_val_q;
    sa_addr_d    = sa_addr_q;
    rng_ctl_o    = '0;

    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (&clr_q) begin
          state_d = clr_item_q ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          res_heat_d   = 8'd0;
          res_status_d = vfh_pkg::STATUS_OK;
          unique case (kind_i)
            vfh_pkg::KIND_TICK: begin
              if (enabled_i) begin
                x_d     = '0;
                z_d     = '0;
                fin_d   = 1'b0;
                state_d = S_SEED;
              end else begin
                res_status_d = vfh_pkg::STATUS_DISABLED;
                state_d      = S_RESP;
              end
            end
            vfh_pkg::KIND_READ: begin
              if (in_range) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = cell_addr(XW'(cell_x_i), YW'(cell_y_i), ZW'(cell_z_i));
                state_d     = S_CELL;
              end else begin
                res_status_d = vfh_pkg::STATUS_RANGE;
                state_d      = S_RESP;
              end
            end
            vfh_pkg::KIND_CLEAR: begin
              rng_ctl_o.load = 1'b1;
              clr_d          = '0;
              clr_item_d     = 1'b1;
              state_d        = S_CLEAR;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_SEED: begin
        rng_ctl_o.advance = 1'b1;
        sa_v_d            = 1'b1;
        sa_val_d          = draw_i;
        sa_addr_d         = cell_addr(x_q, bottom, z_q);
        if (!x_last) begin
          x_d = XW'(x_next);
        end else begin
          x_d = '0;
          if (!z_last) begin
            z_d = ZW'(z_next);
          end else begin
            z_d     = '0;
            y_d     = YW'(h_i - YS'(2));
            state_d = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        // Interlock: the next layer reads what the pipeline is still writing.
        if (!pipe_busy) begin
          state_d = fin_q ? S_RESP : S_RC;
        end
      end
      S_RC: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = cell_addr(x_q, below, z_q);
        rd_tag_d    = TAG_CENTER;
        rd_ok_d     = 1'b1;
        state_d     = S_RR;
      end
      S_RR: begin
        mem_re_o    = !x_last;
        mem_raddr_o = cell_addr(XW'(x_next), below, z_q);
        rd_tag_d    = TAG_RIGHT;
        rd_ok_d     = !x_last;
        state_d     = S_RU;
      end
      S_RU: begin
        mem_re_o    = (z_q != '0);
        mem_raddr_o = cell_addr(x_q, below, z_q - ZW'(1));
        rd_tag_d    = TAG_ZMINUS;
        rd_ok_d     = (z_q != '0);
        state_d     = S_RD;
      end
      S_RD: begin
        mem_re_o    = !z_last;
        mem_raddr_o = cell_addr(x_q, below, ZW'(z_next));
        rd_tag_d    = TAG_ZPLUS;
        rd_ok_d     = !z_last;
        rd_cell_d   = cell_addr(x_q, y_q, z_q);
        if (!x_last) begin
          x_d     = XW'(x_next);
          state_d = S_RR;
        end else begin
          x_d = '0;
          if (!z_last) begin
            z_d     = ZW'(z_next);
            state_d = S_RC;
          end else begin
            z_d     = '0;
            state_d = S_DRAIN;
            if (y_q == '0) begin
              fin_d = 1'b1;
            end else begin
              y_d = y_q - YW'(1);
            end
          end
        end
      end
      S_CELL: begin
        res_heat_d = mem_rdata_i;
        state_d    = S_RESP;
      end
      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (avg_hot) begin
      rng_ctl_o.advance = 1'b1;
    end
  end

  // Sliding window over the layer below; the right cell becomes the next center.
  assign rd_val = rd_ok_q ? mem_rdata_i : 8'd0;

  always_comb begin
    left_d    = left_q;
    mid_d     = mid_q;
    right_d   = right_q;
    zm_d      = zm_q;
    s1_v_d    = 1'b0;
    sum_d     = sum_q;
    s1_addr_d = s1_addr_q;
    unique case (rd_tag_q)
      TAG_CENTER: begin
        left_d = 8'd0;
        mid_d  = mem_rdata_i;
      end
      TAG_RIGHT: begin
        right_d = rd_val;
      end
      TAG_ZMINUS: begin
        zm_d = rd_val;
      end
      TAG_ZPLUS: begin
        s1_v_d    = 1'b1;
        sum_d     = 11'(left_q) + 11'(mid_q) + 11'(right_q) + 11'(zm_q) + 11'(rd_val);
        s1_addr_d = rd_cell_q;
        left_d    = mid_q;
        mid_d     = right_q;
      end
      default: begin
      end
    endcase
  end

  // Divide by five through a reciprocal, exact for sums below 2^14.
  assign avg_d = 8'((23'(sum_q) * 23'(vfh_pkg::Recip5)) >> vfh_pkg::Recip5Shift);

  // Seed value: quotient by 75 is exact or one short, fixed by one subtraction.
  assign sb_quo_d = 10'((33'(sa_val_q) * 33'(vfh_pkg::Recip75)) >> vfh_pkg::Recip75Shift);
  assign rem_full = 17'(sb_val_q) - 17'(sb_quo_q) * 17'(vfh_pkg::SeedSpan);
  assign rem      = (rem_full >= 17'(vfh_pkg::SeedSpan)) ?
                    8'(rem_full - 17'(vfh_pkg::SeedSpan)) : 8'(rem_full);

  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = s2_addr_q;
    mem_wdata_o = avg_q;
    priority if (state_q == S_CLEAR) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = clr_q;
      mem_wdata_o = 8'd0;
    end else if (sb_v_q) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = sb_addr_q;
      mem_wdata_o = 8'(vfh_pkg::SeedBase) + rem;
    end else if (s2_v_q) begin
      mem_we_o    = 1'b1;
      mem_wdata_o = avg_hot ? (avg_q - {6'd0, draw_i[1:0]}) : avg_q;
    end
  end

  assign res_o.valid  = (state_q == S_RESP);
  assign res_o.heat   = res_heat_q;
  assign res_o.status = res_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      x_q        <= '0;
      y_q        <= '0;
      z_q        <= '0;
      clr_q      <= '0;
      clr_item_q <= 1'b0;
      fin_q      <= 1'b0;
      rd_tag_q   <= TAG_NONE;
      rd_ok_q    <= 1'b0;
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
      sa_v_q     <= 1'b0;
      sb_v_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      x_q        <= x_d;
      y_q        <= y_d;
      z_q        <= z_d;
      clr_q      <= clr_d;
      clr_item_q <= clr_item_d;
      fin_q      <= fin_d;
      rd_tag_q   <= rd_tag_d;
      rd_ok_q    <= rd_ok_d;
      s1_v_q     <= s1_v_d;
      s2_v_q     <= s1_v_q;
      sa_v_q     <= sa_v_d;
      sb_v_q     <= sa_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_heat_q   <= res_heat_d;
    res_status_q <= res_status_d;
    rd_cell_q    <= rd_cell_d;
    left_q       <= left_d;
    mid_q        <= mid_d;
    right_q      <= right_d;
    zm_q         <= zm_d;
    sum_q        <= sum_d;
    s1_addr_q    <= s1_addr_d;
    avg_q        <= avg_d;
    s2_addr_q    <= s1_addr_q;
    sa_val_q     <= sa_val_d;
    sa_addr_q    <= sa_addr_d;
    sb_val_q     <= sa_val_q;
    sb_addr_q    <= sa_addr_q;
    sb_quo_q     <= sb_quo_d;
  end

  `VFH_ASSERT(a_rng_excl, !(rng_ctl_o.load && rng_ctl_o.advance), "rng load and advance together")
  `VFH_ASSERT(a_no_overlap, !(mem_we_o && mem_re_o && (mem_waddr_o == mem_raddr_o)), "read of a cell being written")
  `VFH_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready right after accept")

endmodule
